@@ hw/rtl/sstf_disk_request_scheduler_top_assert.svh @@
// ----------------------------------------------------------------------------
// SSTF scheduler assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SSTF_DISK_REQUEST_SCHEDULER_TOP_ASSERT_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SSTF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sstf scheduler assertion failed");

`define SSTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sstf scheduler assertion failed");

`else

`define SSTF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define SSTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/sstf_pkg.sv @@
// ----------------------------------------------------------------------------
// SSTF scheduler package
// Shared constants, register codes and cell control type.
// ----------------------------------------------------------------------------
`default_nettype none

package sstf_pkg;

    localparam int DEF_QUEUE_DEPTH    = 16;
    localparam int DEF_TRACK_BITS     = 16;
    localparam int DEF_REQUESTER_BITS = 4;

    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_QUEUE       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUESTER_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] RST_MAX_QUEUE       = 5'd4;
    localparam logic [CFG_W-1:0] RST_REQUESTER_COUNT = 5'd16;

    typedef struct packed {
        logic insert;
        logic clear;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/sstf_cell.sv @@
// ----------------------------------------------------------------------------
// SSTF queue cell
// One queue slot plus one stage of the nearest-track candidate chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_cell #(
    parameter int QUEUE_DEPTH    = sstf_pkg::DEF_QUEUE_DEPTH,
    parameter int TRACK_BITS     = sstf_pkg::DEF_TRACK_BITS,
    parameter int REQUESTER_BITS = sstf_pkg::DEF_REQUESTER_BITS,
    parameter int CELL_IDX       = 0
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  sstf_pkg::cell_ctl_t                ctl,
    input  wire                                free_in,
    output logic                               free_out,
    input  wire  [REQUESTER_BITS-1:0]          in_requester,
    input  wire  [TRACK_BITS-1:0]              in_track,
    input  wire                                in_final,
    input  wire  [TRACK_BITS-1:0]              head,
    input  wire                                prev_valid,
    input  wire  [TRACK_BITS-1:0]              prev_dist,
    input  wire  [$clog2(QUEUE_DEPTH)-1:0]     prev_age,
    input  wire  [$clog2(QUEUE_DEPTH)-1:0]     prev_idx,
    input  wire  [REQUESTER_BITS-1:0]          prev_requester,
    input  wire  [TRACK_BITS-1:0]              prev_track,
    input  wire                                prev_final,
    output logic                               cand_valid,
    output logic [TRACK_BITS-1:0]              cand_dist,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     cand_age,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     cand_idx,
    output logic [REQUESTER_BITS-1:0]          cand_requester,
    output logic [TRACK_BITS-1:0]              cand_track,
    output logic                               cand_final
);

    localparam int AGE_W = $clog2(QUEUE_DEPTH);
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(QUEUE_DEPTH - 1);
    localparam logic [AGE_W-1:0] MY_IDX  = AGE_W'(CELL_IDX);

    logic                      valid_reg;
    logic [REQUESTER_BITS-1:0] requester_reg;
    logic [TRACK_BITS-1:0]     track_reg;
    logic                      final_reg;
    logic [AGE_W-1:0]          age_reg;

    logic                      cand_valid_reg;
    logic [TRACK_BITS-1:0]     cand_dist_reg;
    logic [AGE_W-1:0]          cand_age_reg;
    logic [AGE_W-1:0]          cand_idx_reg;
    logic [REQUESTER_BITS-1:0] cand_requester_reg;
    logic [TRACK_BITS-1:0]     cand_track_reg;
    logic                      cand_final_reg;

    logic                      load;
    logic [TRACK_BITS-1:0]     own_dist;
    logic                      take_own;

    assign free_out = free_in | ~valid_reg;
    assign load     = ctl.insert & ~valid_reg & ~free_in;

    assign own_dist = (track_reg >= head) ? (track_reg - head) : (head - track_reg);
    assign take_own = valid_reg & (~prev_valid | (own_dist < prev_dist) |
                      ((own_dist == prev_dist) & (age_reg > prev_age)));

    // slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            requester_reg <= in_requester;
            track_reg     <= in_track;
            final_reg     <= in_final;
            age_reg       <= '0;
        end
        else if (ctl.insert && valid_reg && (age_reg < AGE_MAX))
        begin
            age_reg <= age_reg + AGE_W'(1);
        end
    end

    // candidate stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_valid_reg <= 1'b0;
        end
        else
        begin
            cand_valid_reg <= prev_valid | valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_own)
        begin
            cand_dist_reg      <= own_dist;
            cand_age_reg       <= age_reg;
            cand_idx_reg       <= MY_IDX;
            cand_requester_reg <= requester_reg;
            cand_track_reg     <= track_reg;
            cand_final_reg     <= final_reg;
        end
        else
        begin
            cand_dist_reg      <= prev_dist;
            cand_age_reg       <= prev_age;
            cand_idx_reg       <= prev_idx;
            cand_requester_reg <= prev_requester;
            cand_track_reg     <= prev_track;
            cand_final_reg     <= prev_final;
        end
    end

    assign cand_valid     = cand_valid_reg;
    assign cand_dist      = cand_dist_reg;
    assign cand_age       = cand_age_reg;
    assign cand_idx       = cand_idx_reg;
    assign cand_requester = cand_requester_reg;
    assign cand_track     = cand_track_reg;
    assign cand_final     = cand_final_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sstf_disk_request_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// SSTF disk request scheduler
// Bounded request queue serviced by shortest seek time first.
// ----------------------------------------------------------------------------
// Each request beat is queued in a row of slot cells, if one is free. While
// the queue holds at least min(live requesters, max_queue, QUEUE_DEPTH)
// entries, the entry nearest the head track is serviced (ties to the oldest
// entry) and sent out as one beat; the last beat caused by a request carries
// tlast. Each service waits while the nearest-track candidate travels the
// cell row one cell per cycle; output back-pressure adds to this. The next
// request is taken once the previous one has placed its last beat in the
// output register.
`default_nettype none

`include "sstf_disk_request_scheduler_top_assert.svh"

module sstf_disk_request_scheduler_top #(
    parameter int QUEUE_DEPTH    = sstf_pkg::DEF_QUEUE_DEPTH,
    parameter int TRACK_BITS     = sstf_pkg::DEF_TRACK_BITS,
    parameter int REQUESTER_BITS = sstf_pkg::DEF_REQUESTER_BITS,
    localparam int DATA_W        = ((REQUESTER_BITS + TRACK_BITS + 7) / 8) * 8
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_we,
    input  wire  [sstf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [sstf_pkg::CFG_W-1:0]    cfg_data,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [DATA_W-1:0]             s_tdata,  // requester, track
    input  wire                           s_tlast,  // final_request
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [DATA_W-1:0]             m_tdata,  // served_requester, served_track
    output logic                          m_tlast   // last_of_run
);

    localparam int AGE_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CW    = (CNT_W > sstf_pkg::CFG_W) ? CNT_W : sstf_pkg::CFG_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    logic [1:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            served_reg, served_next;
    logic [CNT_W-1:0]            timer_reg, timer_next;
    logic [sstf_pkg::CFG_W-1:0]  live_reg, live_next;
    logic [sstf_pkg::CFG_W-1:0]  max_queue_reg, max_queue_next;
    logic [TRACK_BITS-1:0]       head_reg, head_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [REQUESTER_BITS-1:0]   pend_requester_reg, pend_requester_next;
    logic [TRACK_BITS-1:0]       pend_track_reg, pend_track_next;
    logic                        out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]           out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;

    logic                        c_valid     [QUEUE_DEPTH+1];
    logic [TRACK_BITS-1:0]       c_dist      [QUEUE_DEPTH+1];
    logic [AGE_W-1:0]            c_age       [QUEUE_DEPTH+1];
    logic [AGE_W-1:0]            c_idx       [QUEUE_DEPTH+1];
    logic [REQUESTER_BITS-1:0]   c_requester [QUEUE_DEPTH+1];
    logic [TRACK_BITS-1:0]       c_track     [QUEUE_DEPTH+1];
    logic                        c_final     [QUEUE_DEPTH+1];
    logic                        free_chain  [QUEUE_DEPTH+1];

    logic                        accept;
    logic                        serve;
    logic                        out_free;
    logic                        more;
    logic [sstf_pkg::CFG_W-1:0]  thr_raw;
    logic [CW-1:0]               thr;

    assign accept   = s_tvalid & s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign serve    = (state_reg == ST_SEARCH) && (timer_reg == DEPTH_C);
    assign out_free = ~out_valid_reg | m_tready;

    assign thr_raw = (live_reg < max_queue_reg) ? live_reg : max_queue_reg;
    assign thr     = (CW'(thr_raw) > CW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(thr_raw);
    assign more    = (count_reg != '0) && (CW'(count_reg) >= thr) && (served_reg < DEPTH_C);

    // head of the candidate chain
    assign c_valid[0]     = 1'b0;
    assign c_dist[0]      = '0;
    assign c_age[0]       = '0;
    assign c_idx[0]       = '0;
    assign c_requester[0] = '0;
    assign c_track[0]     = '0;
    assign c_final[0]     = 1'b0;
    assign free_chain[0]  = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            sstf_pkg::cell_ctl_t ctl;

            assign ctl.insert = accept;
            assign ctl.clear  = serve && (c_idx[QUEUE_DEPTH] == AGE_W'(gi));

            sstf_cell #(
                .QUEUE_DEPTH    (QUEUE_DEPTH),
                .TRACK_BITS     (TRACK_BITS),
                .REQUESTER_BITS (REQUESTER_BITS),
                .CELL_IDX       (gi)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctl            (ctl),
                .free_in        (free_chain[gi]),
                .free_out       (free_chain[gi+1]),
                .in_requester   (s_tdata[REQUESTER_BITS-1:0]),
                .in_track       (s_tdata[REQUESTER_BITS +: TRACK_BITS]),
                .in_final       (s_tlast),
                .head           (head_reg),
                .prev_valid     (c_valid[gi]),
                .prev_dist      (c_dist[gi]),
                .prev_age       (c_age[gi]),
                .prev_idx       (c_idx[gi]),
                .prev_requester (c_requester[gi]),
                .prev_track     (c_track[gi]),
                .prev_final     (c_final[gi]),
                .cand_valid     (c_valid[gi+1]),
                .cand_dist      (c_dist[gi+1]),
                .cand_age       (c_age[gi+1]),
                .cand_idx       (c_idx[gi+1]),
                .cand_requester (c_requester[gi+1]),
                .cand_track     (c_track[gi+1]),
                .cand_final     (c_final[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next          = state_reg;
        count_next          = count_reg;
        served_next         = served_reg;
        timer_next          = timer_reg;
        live_next           = live_reg;
        max_queue_next      = max_queue_reg;
        head_next           = head_reg;
        pend_valid_next     = pend_valid_reg;
        pend_requester_next = pend_requester_reg;
        pend_track_next     = pend_track_reg;
        out_valid_next      = out_valid_reg & ~m_tready;
        out_data_next       = out_data_reg;
        out_last_next       = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    served_next = '0;
                    if (count_reg != DEPTH_C)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = DATA_W'({pend_track_reg, pend_requester_reg});
                        out_last_next   = ~more;
                        pend_valid_next = 1'b0;
                        timer_next      = '0;
                        state_next      = more ? ST_SEARCH : ST_IDLE;
                    end
                end
                else
                begin
                    timer_next = '0;
                    state_next = more ? ST_SEARCH : ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (serve)
                begin
                    pend_valid_next     = 1'b1;
                    pend_requester_next = c_requester[QUEUE_DEPTH];
                    pend_track_next     = c_track[QUEUE_DEPTH];
                    head_next           = c_track[QUEUE_DEPTH];
                    if (c_final[QUEUE_DEPTH] && (live_reg != '0))
                    begin
                        live_next = live_reg - sstf_pkg::CFG_W'(1);
                    end
                    count_next  = count_reg - CNT_W'(1);
                    served_next = served_reg + CNT_W'(1);
                    state_next  = ST_CHECK;
                end
                else
                begin
                    timer_next = timer_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                sstf_pkg::REG_MAX_QUEUE:       max_queue_next = cfg_data;
                sstf_pkg::REG_REQUESTER_COUNT: live_next      = cfg_data;
                default:                       max_queue_next = max_queue_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            served_reg     <= '0;
            timer_reg      <= '0;
            live_reg       <= sstf_pkg::RST_REQUESTER_COUNT;
            max_queue_reg  <= sstf_pkg::RST_MAX_QUEUE;
            head_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            served_reg     <= served_next;
            timer_reg      <= timer_next;
            live_reg       <= live_next;
            max_queue_reg  <= max_queue_next;
            head_reg       <= head_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_requester_reg <= pend_requester_next;
        pend_track_reg     <= pend_track_next;
        out_data_reg       <= out_data_next;
        out_last_reg       <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `SSTF_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_C)
    `SSTF_ASSERT_IMPL(a_serve_has_winner, clk, rst_n, serve, c_valid[QUEUE_DEPTH])
    `SSTF_ASSERT_IMPL(a_search_nonempty, clk, rst_n, state_reg == ST_SEARCH, count_reg != '0)
    `SSTF_ASSERT_NEXT(a_serve_to_check, clk, rst_n, serve, state_reg == ST_CHECK && pend_valid_reg)

endmodule

`default_nettype wire
